FILE: design/wrv_pkg.sv
package wrv_pkg;

  localparam int POS_W     = 16;
  localparam int TIME_W    = 32;
  localparam int TAU_W     = 17;
  localparam int RES_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int WIDE_W    = 64;
  localparam int CFG_W     = 5;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd9;

  // operand selects for the per-sample multiply-accumulate
  localparam logic [2:0] MAC_TT = 3'd0;
  localparam logic [2:0] MAC_TX = 3'd1;
  localparam logic [2:0] MAC_TY = 3'd2;
  localparam logic [2:0] MAC_TH = 3'd3;

  // product pairs: determinant, three slopes, two intercepts
  localparam logic [2:0] PAIR_DET = 3'd0;
  localparam logic [2:0] PAIR_VX  = 3'd1;
  localparam logic [2:0] PAIR_VY  = 3'd2;
  localparam logic [2:0] PAIR_VH  = 3'd3;
  localparam logic [2:0] PAIR_OX  = 3'd4;
  localparam logic [2:0] PAIR_OY  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_TAU,
    S_MAC,
    S_MLOAD,
    S_MSTEP,
    S_MNEXT,
    S_DCHK,
    S_DLOAD,
    S_DSTEP,
    S_DSTORE,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_CLEAR,
    DP_READ,
    DP_TAU,
    DP_MAC,
    DP_MUL_LOAD,
    DP_MUL_STEP,
    DP_PAIR_LATCH,
    DP_PAIR_DIFF,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_DIV_STORE,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] sel;
    logic       half;
  } dp_cmd_t;

  typedef struct packed {
    logic few;
    logic last;
    logic tau_bad;
    logic det_bad;
  } dp_stat_t;

endpackage

FILE: design/wrv_datapath.sv
module wrv_datapath #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wrv_pkg::CFG_W-1:0]           cfg_wdata,
  input  wrv_pkg::dp_cmd_t                    cmd,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]     k,
  input  logic signed [wrv_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [wrv_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [wrv_pkg::POS_W-1:0]    in_orientation,
  input  logic [wrv_pkg::TIME_W-1:0]          in_time_ms,
  output wrv_pkg::dp_stat_t                   stat,
  output logic signed [wrv_pkg::RES_W-1:0]    out_vel_x,
  output logic signed [wrv_pkg::RES_W-1:0]    out_vel_y,
  output logic signed [wrv_pkg::RES_W-1:0]    out_ang_vel,
  output logic signed [wrv_pkg::RES_W-1:0]    out_origin_x,
  output logic signed [wrv_pkg::RES_W-1:0]    out_origin_y,
  output logic                                out_valid_res
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int CMPW  = ((FW > wrv_pkg::CFG_W) ? FW : wrv_pkg::CFG_W) + 1;
  localparam int ST_W  = wrv_pkg::TAU_W + FW;
  localparam int SP_W  = wrv_pkg::POS_W + FW;
  localparam int STT_W = 2 * wrv_pkg::TAU_W + FW;
  localparam int STP_W = wrv_pkg::TAU_W + wrv_pkg::POS_W + FW;
  localparam int PW    = 2 * wrv_pkg::TAU_W;
  localparam int WW    = wrv_pkg::WIDE_W;
  localparam int RW    = wrv_pkg::RES_W;

  // sample stores
  logic signed [wrv_pkg::POS_W-1:0] x_mem_r [WINDOW_DEPTH];
  logic signed [wrv_pkg::POS_W-1:0] y_mem_r [WINDOW_DEPTH];
  logic signed [wrv_pkg::POS_W-1:0] h_mem_r [WINDOW_DEPTH];
  logic [wrv_pkg::TIME_W-1:0]       t_mem_r [WINDOW_DEPTH];

  logic signed [wrv_pkg::POS_W-1:0] rd_x_r, rd_y_r, rd_h_r;
  logic [wrv_pkg::TIME_W-1:0]       rd_t_r;

  logic [wrv_pkg::CFG_W-1:0]  cfg_r;
  logic [FW-1:0]              fill_r, fill_nxt;
  logic [AW-1:0]              slot_r, slot_nxt;
  logic [wrv_pkg::TIME_W-1:0] latest_r;

  logic [CMPW-1:0] cfg_ext, depth_c, eff, fill_inc;
  logic [AW:0]     rd_tmp;
  logic [AW-1:0]   rd_addr;

  logic [wrv_pkg::TIME_W-1:0]        tau_d;
  logic signed [wrv_pkg::TAU_W-1:0]  tau_cur, tau_r, mac_opnd;
  logic signed [PW-1:0]              mac_prod;

  logic signed [ST_W-1:0]  st_r;
  logic signed [SP_W-1:0]  sx_r, sy_r, sh_r;
  logic signed [STT_W-1:0] stt_r;
  logic signed [STP_W-1:0] stx_r, sty_r, sth_r;

  // shift-add multiplier
  logic signed [WW-1:0]   mul_a;
  logic signed [ST_W-1:0] mul_b;
  logic [WW-1:0]          ma_r, macc_r;
  logic [ST_W-1:0]        mb_r;
  logic                   mneg_r;
  logic signed [WW-1:0]   mres;
  logic signed [WW-1:0]   p1_r, num_r, det_r;

  // restoring divider
  logic [WW-1:0]               mag, det_sh, rem_r;
  logic [WW:0]                 div_t, div_d;
  logic                        div_ge;
  logic [wrv_pkg::FRAC_W-1:0]  dlo_r;
  logic [RW-1:0]               q_r, lim, resm, resv;
  logic                        dneg_r, dsat_r;

  logic signed [RW-1:0] res_vx_r, res_vy_r, res_vh_r, res_ox_r, res_oy_r;
  logic                 res_valid_r;

  // window bookkeeping
  always_comb begin
    cfg_ext  = CMPW'(cfg_r);
    depth_c  = CMPW'(WINDOW_DEPTH);
    if (cfg_ext == '0) begin
      eff = CMPW'(1);
    end else if (cfg_ext > depth_c) begin
      eff = depth_c;
    end else begin
      eff = cfg_ext;
    end
    fill_inc = CMPW'(fill_r) + CMPW'(1);
    fill_nxt = (fill_inc > eff) ? FW'(eff) : FW'(fill_inc);
    slot_nxt = (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + AW'(1);
    rd_tmp   = (AW+1)'(slot_r) + (AW+1)'(WINDOW_DEPTH - 1) - (AW+1)'(k);
    rd_addr  = (rd_tmp >= (AW+1)'(WINDOW_DEPTH)) ?
               AW'(rd_tmp - (AW+1)'(WINDOW_DEPTH)) : AW'(rd_tmp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= wrv_pkg::CFG_RESET;
      fill_r   <= '0;
      slot_r   <= '0;
      latest_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      case (cmd.op)
        wrv_pkg::DP_PUSH: begin
          fill_r   <= fill_nxt;
          slot_r   <= slot_nxt;
          latest_r <= in_time_ms;
        end
        wrv_pkg::DP_CLEAR: begin
          fill_r   <= '0;
          slot_r   <= '0;
          latest_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == wrv_pkg::DP_PUSH) begin
      x_mem_r[slot_r] <= in_pos_x;
      y_mem_r[slot_r] <= in_pos_y;
      h_mem_r[slot_r] <= in_orientation;
      t_mem_r[slot_r] <= in_time_ms;
    end
    if (cmd.op == wrv_pkg::DP_READ) begin
      rd_x_r <= x_mem_r[rd_addr];
      rd_y_r <= y_mem_r[rd_addr];
      rd_h_r <= h_mem_r[rd_addr];
      rd_t_r <= t_mem_r[rd_addr];
    end
  end

  // offset from newest stamp; valid only if it fits 17 bits signed
  assign tau_d   = rd_t_r - latest_r;
  assign tau_cur = $signed(tau_d[wrv_pkg::TAU_W-1:0]);

  always_comb begin
    case (cmd.sel)
      wrv_pkg::MAC_TT: mac_opnd = tau_r;
      wrv_pkg::MAC_TX: mac_opnd = wrv_pkg::TAU_W'(rd_x_r);
      wrv_pkg::MAC_TY: mac_opnd = wrv_pkg::TAU_W'(rd_y_r);
      wrv_pkg::MAC_TH: mac_opnd = wrv_pkg::TAU_W'(rd_h_r);
      default:         mac_opnd = '0;
    endcase
  end
  assign mac_prod = tau_r * mac_opnd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      wrv_pkg::PAIR_DET: begin
        mul_a = cmd.half ? WW'(st_r) : WW'(stt_r);
        mul_b = cmd.half ? st_r : $signed(ST_W'(fill_r));
      end
      wrv_pkg::PAIR_VX: begin
        mul_a = cmd.half ? WW'(sx_r) : WW'(stx_r);
        mul_b = cmd.half ? st_r : $signed(ST_W'(fill_r));
      end
      wrv_pkg::PAIR_VY: begin
        mul_a = cmd.half ? WW'(sy_r) : WW'(sty_r);
        mul_b = cmd.half ? st_r : $signed(ST_W'(fill_r));
      end
      wrv_pkg::PAIR_VH: begin
        mul_a = cmd.half ? WW'(sh_r) : WW'(sth_r);
        mul_b = cmd.half ? st_r : $signed(ST_W'(fill_r));
      end
      wrv_pkg::PAIR_OX: begin
        mul_a = cmd.half ? WW'(stx_r) : WW'(stt_r);
        mul_b = cmd.half ? st_r : ST_W'(sx_r);
      end
      wrv_pkg::PAIR_OY: begin
        mul_a = cmd.half ? WW'(sty_r) : WW'(stt_r);
        mul_b = cmd.half ? st_r : ST_W'(sy_r);
      end
      default: ;
    endcase
  end

  assign mres = mneg_r ? $signed(WW'(0) - macc_r) : $signed(macc_r);

  assign mag    = num_r[WW-1] ? WW'(0) - WW'(num_r) : WW'(num_r);
  assign det_sh = WW'(det_r) << wrv_pkg::FRAC_W;
  assign div_t  = {rem_r, dlo_r[wrv_pkg::FRAC_W-1]};
  assign div_d  = {1'b0, WW'(det_r)};
  assign div_ge = (div_t >= div_d);

  always_comb begin
    lim  = dneg_r ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    resm = (dsat_r || (q_r > lim)) ? lim : q_r;
    resv = dneg_r ? RW'(0) - resm : resm;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      wrv_pkg::DP_PUSH, wrv_pkg::DP_CLEAR: begin
        st_r        <= '0;
        sx_r        <= '0;
        sy_r        <= '0;
        sh_r        <= '0;
        stt_r       <= '0;
        stx_r       <= '0;
        sty_r       <= '0;
        sth_r       <= '0;
        res_vx_r    <= '0;
        res_vy_r    <= '0;
        res_vh_r    <= '0;
        res_ox_r    <= '0;
        res_oy_r    <= '0;
        res_valid_r <= 1'b0;
      end
      wrv_pkg::DP_TAU: begin
        tau_r <= tau_cur;
        st_r  <= st_r + ST_W'(tau_cur);
        sx_r  <= sx_r + SP_W'(rd_x_r);
        sy_r  <= sy_r + SP_W'(rd_y_r);
        sh_r  <= sh_r + SP_W'(rd_h_r);
      end
      wrv_pkg::DP_MAC: begin
        case (cmd.sel)
          wrv_pkg::MAC_TT: stt_r <= stt_r + STT_W'(mac_prod);
          wrv_pkg::MAC_TX: stx_r <= stx_r + STP_W'(mac_prod);
          wrv_pkg::MAC_TY: sty_r <= sty_r + STP_W'(mac_prod);
          wrv_pkg::MAC_TH: sth_r <= sth_r + STP_W'(mac_prod);
          default: ;
        endcase
      end
      wrv_pkg::DP_MUL_LOAD: begin
        ma_r   <= WW'(mul_a);
        mb_r   <= mul_b[ST_W-1] ? ST_W'(0) - ST_W'(mul_b) : ST_W'(mul_b);
        mneg_r <= mul_b[ST_W-1];
        macc_r <= '0;
      end
      wrv_pkg::DP_MUL_STEP: begin
        if (mb_r[0]) begin
          macc_r <= macc_r + ma_r;
        end
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
      wrv_pkg::DP_PAIR_LATCH: p1_r <= mres;
      wrv_pkg::DP_PAIR_DIFF: begin
        num_r <= p1_r - mres;
        if (cmd.sel == wrv_pkg::PAIR_DET) begin
          det_r <= p1_r - mres;
        end
      end
      wrv_pkg::DP_DIV_LOAD: begin
        dneg_r <= num_r[WW-1];
        dsat_r <= (mag >= det_sh);
        rem_r  <= mag >> wrv_pkg::FRAC_W;
        dlo_r  <= mag[wrv_pkg::FRAC_W-1:0];
        q_r    <= '0;
      end
      wrv_pkg::DP_DIV_STEP: begin
        rem_r <= div_ge ? WW'(div_t - div_d) : div_t[WW-1:0];
        q_r   <= {q_r[RW-2:0], div_ge};
        dlo_r <= dlo_r << 1;
      end
      wrv_pkg::DP_DIV_STORE: begin
        case (cmd.sel)
          wrv_pkg::PAIR_VX: res_vx_r <= $signed(resv);
          wrv_pkg::PAIR_VY: res_vy_r <= $signed(resv);
          wrv_pkg::PAIR_VH: res_vh_r <= $signed(resv);
          wrv_pkg::PAIR_OX: res_ox_r <= $signed(resv);
          wrv_pkg::PAIR_OY: begin
            res_oy_r    <= $signed(resv);
            res_valid_r <= 1'b1;
          end
          default: ;
        endcase
      end
      wrv_pkg::DP_OUT_LOAD: begin
        out_vel_x     <= res_vx_r;
        out_vel_y     <= res_vy_r;
        out_ang_vel   <= res_vh_r;
        out_origin_x  <= res_ox_r;
        out_origin_y  <= res_oy_r;
        out_valid_res <= res_valid_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.few     = (fill_r < FW'(2));
    stat.last    = ((FW'(k) + FW'(1)) == fill_r);
    stat.tau_bad = !((tau_d[wrv_pkg::TIME_W-1:wrv_pkg::TAU_W-1] == '0) ||
                     (tau_d[wrv_pkg::TIME_W-1:wrv_pkg::TAU_W-1] == '1));
    stat.det_bad = (det_r <= 0);
  end

endmodule

FILE: design/wrv_controller.sv
module wrv_controller #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_action,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  wrv_pkg::dp_stat_t               stat,
  output wrv_pkg::dp_cmd_t                cmd,
  output logic [$clog2(WINDOW_DEPTH)-1:0] k
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int ST_W  = wrv_pkg::TAU_W + $clog2(WINDOW_DEPTH + 1);
  localparam int CW    = wrv_pkg::CNT_W;

  wrv_pkg::ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [2:0]    j_r, j_nxt, m_r, m_nxt;
  logic          half_r, half_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrv_pkg::S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      m_r     <= '0;
      half_r  <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      m_r     <= m_nxt;
      half_r  <= half_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    half_nxt  = half_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && out_stall;
    cmd.op    = wrv_pkg::DP_NOP;
    cmd.sel   = m_r;
    cmd.half  = half_r;
    case (state_r)
      wrv_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = in_action ? wrv_pkg::DP_CLEAR : wrv_pkg::DP_PUSH;
          state_nxt = in_action ? wrv_pkg::S_DONE : wrv_pkg::S_START;
        end
      end
      wrv_pkg::S_START: begin
        k_nxt     = '0;
        state_nxt = stat.few ? wrv_pkg::S_DONE : wrv_pkg::S_READ;
      end
      wrv_pkg::S_READ: begin
        cmd.op    = wrv_pkg::DP_READ;
        state_nxt = wrv_pkg::S_TAU;
      end
      wrv_pkg::S_TAU: begin
        cmd.op = wrv_pkg::DP_TAU;
        j_nxt  = wrv_pkg::MAC_TT;
        state_nxt = stat.tau_bad ? wrv_pkg::S_DONE : wrv_pkg::S_MAC;
      end
      wrv_pkg::S_MAC: begin
        cmd.op  = wrv_pkg::DP_MAC;
        cmd.sel = j_r;
        if (j_r == wrv_pkg::MAC_TH) begin
          if (stat.last) begin
            m_nxt     = wrv_pkg::PAIR_DET;
            half_nxt  = 1'b0;
            state_nxt = wrv_pkg::S_MLOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = wrv_pkg::S_READ;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      wrv_pkg::S_MLOAD: begin
        cmd.op    = wrv_pkg::DP_MUL_LOAD;
        cnt_nxt   = '0;
        state_nxt = wrv_pkg::S_MSTEP;
      end
      wrv_pkg::S_MSTEP: begin
        cmd.op  = wrv_pkg::DP_MUL_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ST_W - 1)) begin
          state_nxt = wrv_pkg::S_MNEXT;
        end
      end
      wrv_pkg::S_MNEXT: begin
        if (!half_r) begin
          cmd.op    = wrv_pkg::DP_PAIR_LATCH;
          half_nxt  = 1'b1;
          state_nxt = wrv_pkg::S_MLOAD;
        end else begin
          cmd.op    = wrv_pkg::DP_PAIR_DIFF;
          half_nxt  = 1'b0;
          state_nxt = (m_r == wrv_pkg::PAIR_DET) ? wrv_pkg::S_DCHK : wrv_pkg::S_DLOAD;
        end
      end
      wrv_pkg::S_DCHK: begin
        m_nxt     = wrv_pkg::PAIR_VX;
        state_nxt = stat.det_bad ? wrv_pkg::S_DONE : wrv_pkg::S_MLOAD;
      end
      wrv_pkg::S_DLOAD: begin
        cmd.op    = wrv_pkg::DP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = wrv_pkg::S_DSTEP;
      end
      wrv_pkg::S_DSTEP: begin
        cmd.op  = wrv_pkg::DP_DIV_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(wrv_pkg::DIV_STEPS - 1)) begin
          state_nxt = wrv_pkg::S_DSTORE;
        end
      end
      wrv_pkg::S_DSTORE: begin
        cmd.op = wrv_pkg::DP_DIV_STORE;
        if (m_r == wrv_pkg::PAIR_OY) begin
          state_nxt = wrv_pkg::S_DONE;
        end else begin
          m_nxt     = m_r + 3'd1;
          state_nxt = wrv_pkg::S_MLOAD;
        end
      end
      wrv_pkg::S_DONE: begin
        if (!ov_r || !out_stall) begin
          cmd.op    = wrv_pkg::DP_OUT_LOAD;
          ov_nxt    = 1'b1;
          state_nxt = wrv_pkg::S_IDLE;
        end
      end
      default: state_nxt = wrv_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != wrv_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign k         = k_r;

endmodule

FILE: design/window_regression_velocity_unit.sv
// Accepting edge to out_valid, push with n >= 2 samples: per sample a read, an offset and
//   four MACs; then the product pairs on the serial multiplier of ST_W bits, ST_W = 17 +
//   clog2(WINDOW_DEPTH+1) (22 at depth 16); the det check; five divides; the output load.
//   Clear goes straight to the output load; a push leaving fewer than two samples, a bad
//   offset or a bad det exits early. One word at a time, set by the one-bit-a-cycle shared
//   multiplier and divider. The next word is taken while a result waits in the output.
// Reset (rst_n low, synchronous): window empty, window_size 9, no result pending.
module window_regression_velocity_unit #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wrv_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic signed [wrv_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [wrv_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [wrv_pkg::POS_W-1:0] in_orientation,
  input  logic [wrv_pkg::TIME_W-1:0]       in_time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [wrv_pkg::RES_W-1:0] out_vel_x,
  output logic signed [wrv_pkg::RES_W-1:0] out_vel_y,
  output logic signed [wrv_pkg::RES_W-1:0] out_ang_vel,
  output logic signed [wrv_pkg::RES_W-1:0] out_origin_x,
  output logic signed [wrv_pkg::RES_W-1:0] out_origin_y,
  output logic                             out_valid_res
);

  // Controller sequences the work: sample loop (read, offset, four MACs per sample),
  // then six product pairs on the serial multiplier (det first, checked before the
  // rest), each numerator followed by a 32-step restoring divide into Q16.16.
  wrv_pkg::dp_cmd_t              cmd;
  wrv_pkg::dp_stat_t             stat;
  logic [$clog2(WINDOW_DEPTH)-1:0] k;

  wrv_controller #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .k         (k)
  );

  // Datapath: sample stores, window bookkeeping, running sums, shared
  // multiplier and divider, result and output word registers.
  wrv_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .k              (k),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_orientation (in_orientation),
    .in_time_ms     (in_time_ms),
    .stat           (stat),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y),
    .out_ang_vel    (out_ang_vel),
    .out_origin_x   (out_origin_x),
    .out_origin_y   (out_origin_y),
    .out_valid_res  (out_valid_res)
  );

endmodule

FILE: design/wrv_checker.sv
module wrv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [wrv_pkg::CFG_W-1:0]        cfg_wdata,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_action,
  input logic signed [wrv_pkg::POS_W-1:0] in_pos_x,
  input logic signed [wrv_pkg::POS_W-1:0] in_pos_y,
  input logic signed [wrv_pkg::POS_W-1:0] in_orientation,
  input logic [wrv_pkg::TIME_W-1:0]       in_time_ms,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [wrv_pkg::RES_W-1:0] out_vel_x,
  input logic signed [wrv_pkg::RES_W-1:0] out_vel_y,
  input logic signed [wrv_pkg::RES_W-1:0] out_ang_vel,
  input logic signed [wrv_pkg::RES_W-1:0] out_origin_x,
  input logic signed [wrv_pkg::RES_W-1:0] out_origin_y,
  input logic                             out_valid_res
);

  // one word in flight: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_vel_x) &&
      $stable(out_origin_y) && $stable(out_valid_res)))
    else $error("result word changed under stall");

  // no-fit results carry zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_vel_x == 0 && out_vel_y == 0 &&
      out_ang_vel == 0 && out_origin_x == 0 && out_origin_y == 0))
    else $error("non-zero fields on a result without fit");

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("state left over after reset");

endmodule

bind window_regression_velocity_unit wrv_checker u_wrv_checker (.*);
